// File: sv/pulse_space_pulse_frame_decoder_defines.svh
// assertion macros shared by the checker files of the frame decoder
// no dependencies; clocked on aclk and held off while aresetn is low
`ifndef PULSE_SPACE_PULSE_FRAME_DECODER_DEFINES_SVH
`define PULSE_SPACE_PULSE_FRAME_DECODER_DEFINES_SVH

// consequent checked in the same cycle as the antecedent
`define PSPF_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the cycle after the antecedent
`define PSPF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/pspf_pkg.sv
// shared types, codes and constants of the pulse-space-pulse frame decoder
// no dependencies; used by every rtl and checker file of the block
package pspf_pkg;

    localparam int TS_W        = 32;
    localparam int PULSE_W     = 16;
    localparam int TIMEOUT_W   = 20;
    localparam int CFG_MAX_W   = 20;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 20;
    localparam int STATION_W   = 4;
    localparam int STATION_MAX = 15;
    localparam int IN_DATA_W   = 40;
    localparam int OUT_DATA_W  = 8;

    localparam int TICK_US_DEF       = 10;
    localparam int SPACE_STEP_US_DEF = 200;

    // durations saturate one bit above the widest register
    localparam int SAT_W = CFG_MAX_W + 1;

    localparam logic CMD_EDGE   = 1'b0;
    localparam logic CMD_TICK   = 1'b1;
    localparam logic LEVEL_RISE = 1'b1;
    localparam logic SIDE_LEFT  = 1'b0;
    localparam logic SIDE_RIGHT = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_PULSE_SPLIT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PULSE_MIN   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PULSE_MAX   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PULSE_TOL   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SPACE_MIN   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SPACE_MAX   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SPACE_BASE  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT     = 3'd7;

    localparam logic [PULSE_W-1:0]   RST_PULSE_SPLIT = 16'd250;
    localparam logic [PULSE_W-1:0]   RST_PULSE_MIN   = 16'd120;
    localparam logic [PULSE_W-1:0]   RST_PULSE_MAX   = 16'd420;
    localparam logic [PULSE_W-1:0]   RST_PULSE_TOL   = 16'd80;
    localparam logic [PULSE_W-1:0]   RST_SPACE_MIN   = 16'd380;
    localparam logic [PULSE_W-1:0]   RST_SPACE_MAX   = 16'd3200;
    localparam logic [PULSE_W-1:0]   RST_SPACE_BASE  = 16'd500;
    localparam logic [TIMEOUT_W-1:0] RST_TIMEOUT     = 20'd10000;

    typedef struct packed {
        logic [PULSE_W-1:0]   pulse_split;
        logic [PULSE_W-1:0]   pulse_min;
        logic [PULSE_W-1:0]   pulse_max;
        logic [PULSE_W-1:0]   pulse_tol;
        logic [PULSE_W-1:0]   space_min;
        logic [PULSE_W-1:0]   space_max;
        logic [PULSE_W-1:0]   space_base;
        logic [TIMEOUT_W-1:0] frame_timeout;
    } cfg_t;

    typedef struct packed {
        logic                 ok;
        logic                 side;
        logic [STATION_W-1:0] station;
    } verdict_t;

    typedef enum logic [3:0] {
        PH_IDLE   = 4'b0001,
        PH_FIRST  = 4'b0010,
        PH_SPACE  = 4'b0100,
        PH_SECOND = 4'b1000
    } phase_t;

endpackage

// File: sv/pspf_span.sv
// tick difference to saturated microseconds, shared by every duration and timeout
// depends on pspf_pkg for the timestamp width
module pspf_span #(
    parameter int TICK_US = pspf_pkg::TICK_US_DEF,
    parameter int SAT_W   = pspf_pkg::SAT_W,
    localparam int SPAN_W = SAT_W + $clog2(TICK_US + 1)
) (
    input  logic [pspf_pkg::TS_W-1:0] from_ts,
    input  logic [pspf_pkg::TS_W-1:0] to_ts,
    output logic [SPAN_W-1:0]         span_us
);

    logic [pspf_pkg::TS_W-1:0] ticks;
    logic [SAT_W-1:0]          sat_ticks;

    // modulo 2^32 difference, clamped just above any register value
    always_comb begin
        ticks = to_ts - from_ts;
        if (|ticks[pspf_pkg::TS_W-1:SAT_W-1]) begin
            sat_ticks = {1'b1, {(SAT_W-1){1'b0}}};
        end else begin
            sat_ticks = {1'b0, ticks[SAT_W-2:0]};
        end
        span_us = SPAN_W'(sat_ticks) * SPAN_W'(TICK_US);
    end

endmodule

// File: sv/pspf_judge.sv
// frame checks on the two pulses and the space, side and station number
// depends on pspf_pkg for the configuration and verdict structs
module pspf_judge #(
    parameter int SPAN_W        = pspf_pkg::SAT_W + 4,
    parameter int SPACE_STEP_US = pspf_pkg::SPACE_STEP_US_DEF
) (
    input  pspf_pkg::cfg_t     cfg,
    input  logic [SPAN_W-1:0]  pulse1_us,
    input  logic [SPAN_W-1:0]  gap_us,
    input  logic [SPAN_W-1:0]  pulse2_us,
    output pspf_pkg::verdict_t verdict
);

    logic                             p1_ok;
    logic                             p2_ok;
    logic                             tol_ok;
    logic                             sp_ok;
    logic [SPAN_W-1:0]                diff;
    logic [SPAN_W-1:0]                excess;
    logic [pspf_pkg::STATION_MAX-1:0] pass;

    always_comb begin
        p1_ok = (pulse1_us >= SPAN_W'(cfg.pulse_min)) && (pulse1_us <= SPAN_W'(cfg.pulse_max));
        p2_ok = (pulse2_us >= SPAN_W'(cfg.pulse_min)) && (pulse2_us <= SPAN_W'(cfg.pulse_max));
        diff  = (pulse1_us > pulse2_us) ? (pulse1_us - pulse2_us) : (pulse2_us - pulse1_us);
        tol_ok = diff <= SPAN_W'(cfg.pulse_tol);
        sp_ok  = (gap_us >= SPAN_W'(cfg.space_min)) && (gap_us <= SPAN_W'(cfg.space_max));
        excess = (gap_us > SPAN_W'(cfg.space_base)) ?
                 (gap_us - SPAN_W'(cfg.space_base)) : '0;
        // rounded division by the step: count the half-step thresholds passed
        for (int k = 1; k <= pspf_pkg::STATION_MAX; k++) begin
            pass[k-1] = 32'(excess) >= 32'(k * SPACE_STEP_US - SPACE_STEP_US / 2);
        end
        verdict.ok      = p1_ok && p2_ok && tol_ok && sp_ok;
        verdict.side    = (pulse1_us < SPAN_W'(cfg.pulse_split)) ?
                          pspf_pkg::SIDE_LEFT : pspf_pkg::SIDE_RIGHT;
        verdict.station = pspf_pkg::STATION_W'($countones(pass));
    end

endmodule

// File: sv/pulse_space_pulse_frame_decoder.sv
// pulse-space-pulse frame decoder: input register, combinational frame logic, result register
// a closing falling edge is held in the input register, and its result then in the result register
// throughput: one request per cycle while results are taken; a waiting result still lets one more request in
// reset: synchronous active-low aresetn returns the machine to idle, loads the
// register defaults and drops any held request or result
module pulse_space_pulse_frame_decoder #(
    parameter int TICK_US       = pspf_pkg::TICK_US_DEF,
    parameter int SPACE_STEP_US = pspf_pkg::SPACE_STEP_US_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [pspf_pkg::IN_DATA_W-1:0]      s_tdata,   // level, timestamp[31:0], zero pad
    input  logic                                s_tuser,   // command
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [pspf_pkg::OUT_DATA_W-1:0]     m_tdata,   // station[3:0], side, zero pad
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [pspf_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [pspf_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int SPAN_W = pspf_pkg::SAT_W + $clog2(TICK_US + 1);

    pspf_pkg::cfg_t             cfg_reg, cfg_next;
    pspf_pkg::phase_t           phase_reg, phase_next;
    logic [pspf_pkg::TS_W-1:0]  last_edge_reg, last_edge_next;
    logic [SPAN_W-1:0]          pulse1_reg, pulse1_next;
    logic [SPAN_W-1:0]          space_reg, space_next;

    logic                       in_valid_reg, in_valid_next;
    logic                       in_cmd_reg;
    logic                       in_level_reg;
    logic [pspf_pkg::TS_W-1:0]  in_ts_reg;

    logic                            m_valid_reg, m_valid_next;
    logic [pspf_pkg::STATION_W-1:0]  m_station_reg;
    logic                            m_side_reg;

    logic                s_accept;
    logic                advance;
    logic                emit;
    logic [SPAN_W-1:0]   span_us;
    pspf_pkg::verdict_t  verdict;

    assign cfg_ready = 1'b1;
    assign advance   = in_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign s_accept  = s_tvalid && s_tready;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = {{(pspf_pkg::OUT_DATA_W - pspf_pkg::STATION_W - 1){1'b0}},
                        m_side_reg, m_station_reg};

    // every duration and the timeout run from the last edge to the current request
    pspf_span #(
        .TICK_US (TICK_US),
        .SAT_W   (pspf_pkg::SAT_W)
    ) u_span (
        .from_ts (last_edge_reg),
        .to_ts   (in_ts_reg),
        .span_us (span_us)
    );

    pspf_judge #(
        .SPAN_W        (SPAN_W),
        .SPACE_STEP_US (SPACE_STEP_US)
    ) u_judge (
        .cfg       (cfg_reg),
        .pulse1_us (pulse1_reg),
        .gap_us    (space_reg),
        .pulse2_us (span_us),
        .verdict   (verdict)
    );

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                pspf_pkg::REG_PULSE_SPLIT: cfg_next.pulse_split = cfg_data[pspf_pkg::PULSE_W-1:0];
                pspf_pkg::REG_PULSE_MIN:   cfg_next.pulse_min   = cfg_data[pspf_pkg::PULSE_W-1:0];
                pspf_pkg::REG_PULSE_MAX:   cfg_next.pulse_max   = cfg_data[pspf_pkg::PULSE_W-1:0];
                pspf_pkg::REG_PULSE_TOL:   cfg_next.pulse_tol   = cfg_data[pspf_pkg::PULSE_W-1:0];
                pspf_pkg::REG_SPACE_MIN:   cfg_next.space_min   = cfg_data[pspf_pkg::PULSE_W-1:0];
                pspf_pkg::REG_SPACE_MAX:   cfg_next.space_max   = cfg_data[pspf_pkg::PULSE_W-1:0];
                pspf_pkg::REG_SPACE_BASE:  cfg_next.space_base  = cfg_data[pspf_pkg::PULSE_W-1:0];
                pspf_pkg::REG_TIMEOUT: begin
                    cfg_next.frame_timeout = cfg_data[pspf_pkg::TIMEOUT_W-1:0];
                end
                default: cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb begin
        phase_next     = phase_reg;
        last_edge_next = last_edge_reg;
        pulse1_next    = pulse1_reg;
        space_next     = space_reg;
        emit           = 1'b0;
        if (advance) begin
            if (in_cmd_reg == pspf_pkg::CMD_TICK) begin
                if (phase_reg != pspf_pkg::PH_IDLE &&
                    span_us > SPAN_W'(cfg_reg.frame_timeout)) begin
                    phase_next = pspf_pkg::PH_IDLE;
                end
            end else begin
                last_edge_next = in_ts_reg;
                if (in_level_reg == pspf_pkg::LEVEL_RISE) begin
                    if (phase_reg == pspf_pkg::PH_SPACE) begin
                        space_next = span_us;
                        phase_next = pspf_pkg::PH_SECOND;
                    end else begin
                        phase_next = pspf_pkg::PH_FIRST;
                    end
                end else begin
                    case (phase_reg)
                        pspf_pkg::PH_FIRST: begin
                            pulse1_next = span_us;
                            phase_next  = pspf_pkg::PH_SPACE;
                        end
                        pspf_pkg::PH_SECOND: begin
                            phase_next = pspf_pkg::PH_IDLE;
                            emit       = verdict.ok;
                        end
                        default: phase_next = pspf_pkg::PH_IDLE;
                    endcase
                end
            end
        end
    end

    always_comb begin
        if (s_accept) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end else begin
            in_valid_next = in_valid_reg;
        end
        if (advance) begin
            m_valid_next = emit;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.pulse_split   <= pspf_pkg::RST_PULSE_SPLIT;
            cfg_reg.pulse_min     <= pspf_pkg::RST_PULSE_MIN;
            cfg_reg.pulse_max     <= pspf_pkg::RST_PULSE_MAX;
            cfg_reg.pulse_tol     <= pspf_pkg::RST_PULSE_TOL;
            cfg_reg.space_min     <= pspf_pkg::RST_SPACE_MIN;
            cfg_reg.space_max     <= pspf_pkg::RST_SPACE_MAX;
            cfg_reg.space_base    <= pspf_pkg::RST_SPACE_BASE;
            cfg_reg.frame_timeout <= pspf_pkg::RST_TIMEOUT;
            phase_reg     <= pspf_pkg::PH_IDLE;
            last_edge_reg <= '0;
            in_valid_reg  <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            cfg_reg       <= cfg_next;
            phase_reg     <= phase_next;
            last_edge_reg <= last_edge_next;
            in_valid_reg  <= in_valid_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    // payload registers carry no reset
    always_ff @(posedge aclk) begin
        pulse1_reg <= pulse1_next;
        space_reg  <= space_next;
        if (s_accept) begin
            in_cmd_reg   <= s_tuser;
            in_level_reg <= s_tdata[0];
            in_ts_reg    <= s_tdata[pspf_pkg::TS_W:1];
        end
        if (advance && emit) begin
            m_station_reg <= verdict.station;
            m_side_reg    <= verdict.side;
        end
    end

endmodule

// File: sv/pspf_checker.sv
// port-level checker for the frame decoder, bound to the top level
// depends on pspf_pkg and pulse_space_pulse_frame_decoder_defines.svh
`include "pulse_space_pulse_frame_decoder_defines.svh"

module pspf_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic [pspf_pkg::IN_DATA_W-1:0]  s_tdata,
    input logic                            s_tuser,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [pspf_pkg::OUT_DATA_W-1:0] m_tdata
);

    // a stalled result holds its value
    `PSPF_ASSERT_NEXT(a_result_held, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result dropped or changed while stalled")

    // with no result waiting the input side never stalls
    `PSPF_ASSERT_SAME(a_ready_when_empty, !m_tvalid, s_tready, "input stalled with empty result register")

    // a fresh result comes from an accepted falling edge that passed the input register and then the result register
    `PSPF_ASSERT_SAME(a_result_source, $rose(m_tvalid), $past(s_tvalid && s_tready && (s_tuser == pspf_pkg::CMD_EDGE) && (s_tdata[0] != pspf_pkg::LEVEL_RISE), 2), "result without a closing falling edge")

endmodule

bind pulse_space_pulse_frame_decoder pspf_checker u_checker (.*);

// File: test/frame_decode_checker.sv
// checker for the pulse-space-pulse frame decoder: watches the request, result and
// register channels, predicts each decoded frame and compares it; needs pspf_pkg
`timescale 1ns / 100ps

module frame_decode_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [pspf_pkg::IN_DATA_W-1:0]  s_tdata,   // level, timestamp[31:0], zero pad
    input  logic                            s_tuser,   // command
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [pspf_pkg::OUT_DATA_W-1:0] m_tdata,   // station[3:0], side, zero pad
    input  logic                            cfg_valid,
    input  logic                            cfg_ready,
    input  logic [pspf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [pspf_pkg::CFG_DATA_W-1:0] cfg_data,
    output int                              fail_count,
    output int                              outstanding
);
    import pspf_pkg::*;

    localparam longint unsigned TICK_US = TICK_US_DEF;
    localparam longint unsigned STEP_US = SPACE_STEP_US_DEF;
    localparam int              REPORT_LIMIT = 10;

    typedef struct packed {
        logic                 side;
        logic [STATION_W-1:0] station;
    } frame_result_t;

    cfg_t              settings;
    phase_t            phase = PH_IDLE;
    logic [TS_W-1:0]   rise1_ts, fall1_ts, rise2_ts, last_edge_ts;
    frame_result_t     decoded_q[$];
    int                failures = 0;

    // tick difference modulo 2^32, scaled to microseconds without wrapping
    function automatic longint unsigned span_us(input logic [TS_W-1:0] from_ts,
                                                input logic [TS_W-1:0] to_ts);
        logic [TS_W-1:0]   ticks;
        longint unsigned   wide;
        ticks = to_ts - from_ts;
        wide = ticks;
        return wide * TICK_US;
    endfunction

    task automatic decode_item(input logic cmd, input logic lvl, input logic [TS_W-1:0] now);
        longint unsigned p1, sp, p2, diff, excess, num;
        frame_result_t   res;
        if (cmd == CMD_TICK) begin
            // a tick never moves the last edge time
            if (phase != PH_IDLE && span_us(last_edge_ts, now) > settings.frame_timeout)
                phase = PH_IDLE;
        end else if (lvl == LEVEL_RISE) begin
            last_edge_ts = now;
            if (phase == PH_SPACE) begin
                rise2_ts = now;
                phase = PH_SECOND;
            end else begin
                rise1_ts = now;
                phase = PH_FIRST;
            end
        end else begin
            last_edge_ts = now;
            if (phase == PH_FIRST) begin
                fall1_ts = now;
                phase = PH_SPACE;
            end else if (phase != PH_SECOND) begin
                phase = PH_IDLE;
            end else begin
                phase = PH_IDLE;
                p1 = span_us(rise1_ts, fall1_ts);
                sp = span_us(fall1_ts, rise2_ts);
                p2 = span_us(rise2_ts, now);
                diff = (p1 > p2) ? p1 - p2 : p2 - p1;
                if (p1 >= settings.pulse_min && p1 <= settings.pulse_max &&
                    p2 >= settings.pulse_min && p2 <= settings.pulse_max &&
                    diff <= settings.pulse_tol &&
                    sp >= settings.space_min && sp <= settings.space_max) begin
                    excess = (sp > settings.space_base) ? sp - settings.space_base : 0;
                    num = (excess + STEP_US / 2) / STEP_US;
                    res.station = (num > STATION_MAX) ? STATION_W'(STATION_MAX) : STATION_W'(num);
                    res.side = (p1 < settings.pulse_split) ? SIDE_LEFT : SIDE_RIGHT;
                    decoded_q.push_back(res);
                end
            end
        end
    endtask

    always @(posedge aclk) begin : monitor
        frame_result_t        want;
        logic [STATION_W-1:0] got_station;
        logic                 got_side;
        if (!aresetn) begin
            settings = '{pulse_split: RST_PULSE_SPLIT, pulse_min: RST_PULSE_MIN,
                         pulse_max: RST_PULSE_MAX, pulse_tol: RST_PULSE_TOL,
                         space_min: RST_SPACE_MIN, space_max: RST_SPACE_MAX,
                         space_base: RST_SPACE_BASE, frame_timeout: RST_TIMEOUT};
            phase = PH_IDLE;
            rise1_ts = '0;
            fall1_ts = '0;
            rise2_ts = '0;
            last_edge_ts = '0;
            decoded_q.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_PULSE_SPLIT: settings.pulse_split   = cfg_data[PULSE_W-1:0];
                    REG_PULSE_MIN:   settings.pulse_min     = cfg_data[PULSE_W-1:0];
                    REG_PULSE_MAX:   settings.pulse_max     = cfg_data[PULSE_W-1:0];
                    REG_PULSE_TOL:   settings.pulse_tol     = cfg_data[PULSE_W-1:0];
                    REG_SPACE_MIN:   settings.space_min     = cfg_data[PULSE_W-1:0];
                    REG_SPACE_MAX:   settings.space_max     = cfg_data[PULSE_W-1:0];
                    REG_SPACE_BASE:  settings.space_base    = cfg_data[PULSE_W-1:0];
                    REG_TIMEOUT:     settings.frame_timeout = cfg_data[TIMEOUT_W-1:0];
                endcase
            end
            // results first, so a request in the same cycle cannot cover for a stray one
            if (m_tvalid && m_tready) begin
                got_station = m_tdata[STATION_W-1:0];
                got_side = m_tdata[STATION_W];
                if (decoded_q.size() == 0) begin
                    if (failures < REPORT_LIMIT)
                        $display("unexpected result: station %0d side %0d at %0t",
                                 got_station, got_side, $realtime);
                    failures++;
                end else begin
                    want = decoded_q.pop_front();
                    if (got_station !== want.station || got_side !== want.side) begin
                        if (failures < REPORT_LIMIT)
                            $display({"result wrong at %0t: expected station %0d side %0d,",
                                      " got station %0d side %0d"}, $realtime,
                                     want.station, want.side, got_station, got_side);
                        failures++;
                    end
                end
            end
            if (s_tvalid && s_tready)
                decode_item(s_tuser, s_tdata[0], s_tdata[TS_W:1]);
        end
        fail_count <= failures;
        outstanding <= decoded_q.size();
    end

endmodule

// File: test/tb_pulse_space_pulse_frame_decoder.sv
// top of the frame decoder testbench: clock, reset, register phases, edge stimulus
// and the verdict; depends on pspf_pkg, the decoder and frame_decode_checker
`timescale 1ns / 100ps

module tb_pulse_space_pulse_frame_decoder;
    import pspf_pkg::*;

    localparam int          WATCHDOG_LIMIT = 2000;
    localparam int          SQUEEZE_CYCLES = 300;
    localparam int          DRAIN_CYCLES   = 8;
    localparam int unsigned TICK_US        = TICK_US_DEF;
    localparam logic        LEVEL_FALL     = ~LEVEL_RISE;

    typedef enum {
        FRAME_CLEAN,
        FRAME_MISSING_RISE,
        FRAME_STALE_TICK,
        FRAME_RESTART
    } frame_flaw_t;

    logic                  aclk;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata   = '0;   // level, timestamp[31:0], zero pad
    logic                  s_tuser   = 1'b0; // command
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;          // station[3:0], side, zero pad
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    int              fail_count;
    int              outstanding;
    int              quiet_cycles = 0;
    int              items_sent   = 0;
    bit              burst        = 1'b0;
    bit              squeeze_req  = 1'b0;
    cfg_t            plan;
    logic [TS_W-1:0] now_ts;

    pulse_space_pulse_frame_decoder dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    frame_decode_checker u_frame_check (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            quiet_cycles <= 0;
        end else if ((s_tvalid && s_tready) || (m_tvalid && m_tready) ||
                     (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("pulse_space_pulse_frame_decoder: mismatch");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // result side: random ready pattern, plus one long hold-off on request
    initial begin : receiver
        int ready_len, hold_len, r;
        while (!aresetn) @(posedge aclk);
        forever begin
            if (squeeze_req) begin
                squeeze_req = 1'b0;
                m_tready <= 1'b0;
                repeat (SQUEEZE_CYCLES) @(posedge aclk);
            end
            ready_len = ($urandom_range(9) == 0) ? $urandom_range(80, 20) : $urandom_range(6, 1);
            m_tready <= 1'b1;
            repeat (ready_len) @(posedge aclk);
            r = $urandom_range(99);
            hold_len = (r < 50) ? 0 : (r < 90) ? $urandom_range(3, 1) : $urandom_range(40, 10);
            if (hold_len > 0) begin
                m_tready <= 1'b0;
                repeat (hold_len) @(posedge aclk);
            end
        end
    end

    function automatic int pick_gap();
        int r;
        if (burst)
            return 0;
        r = $urandom_range(99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(3, 1);
        return $urandom_range(40, 10);
    endfunction

    // tick count spread a little past both ends of a window in microseconds
    function automatic int unsigned near_window(input int unsigned lo_us, input int unsigned hi_us);
        int unsigned lo_t, hi_t;
        lo_t = lo_us / TICK_US;
        hi_t = (hi_us + TICK_US - 1) / TICK_US;
        lo_t = (lo_t > 3) ? lo_t - 3 : 0;
        return $urandom_range(hi_t + 3, lo_t);
    endfunction

    function automatic cfg_t random_plan();
        cfg_t p;
        p.pulse_split   = PULSE_W'($urandom_range(600, 60));
        p.pulse_min     = PULSE_W'($urandom_range(300));
        p.pulse_max     = p.pulse_min + PULSE_W'($urandom_range(600, 20));
        p.pulse_tol     = PULSE_W'($urandom_range(200));
        p.space_min     = PULSE_W'($urandom_range(1000));
        p.space_max     = p.space_min + PULSE_W'($urandom_range(5000, 100));
        p.space_base    = PULSE_W'($urandom_range(2000));
        p.frame_timeout = TIMEOUT_W'($urandom_range(50000, 100));
        return p;
    endfunction

    // called at a clock edge; returns at the edge that takes the request
    task automatic send_item(input logic cmd, input logic lvl, input logic [TS_W-1:0] ts);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= cmd;
        s_tdata <= {{(IN_DATA_W - TS_W - 1){1'b0}}, ts, lvl};
        do @(posedge aclk); while (!s_tready);
        items_sent++;
    endtask

    // elapsed time one tick either side of the timeout limit
    task automatic send_timeout_tick();
        int unsigned limit_t;
        limit_t = plan.frame_timeout / TICK_US;
        send_item(CMD_TICK, 1'($urandom_range(1)), now_ts + limit_t - 1 + $urandom_range(2));
    endtask

    task automatic send_frame();
        int unsigned p1, p2, sp, tol_t, drift, r;
        frame_flaw_t flaw;
        r = $urandom_range(19);
        flaw = (r < 2) ? FRAME_MISSING_RISE : (r < 4) ? FRAME_STALE_TICK :
               (r < 6) ? FRAME_RESTART : FRAME_CLEAN;
        p1 = near_window(plan.pulse_min, plan.pulse_max);
        sp = near_window(plan.space_min, plan.space_max);
        tol_t = plan.pulse_tol / TICK_US + 2;
        if ($urandom_range(3) == 0) begin
            p2 = near_window(plan.pulse_min, plan.pulse_max);
        end else begin
            // second pulse mostly around the first, straddling the tolerance
            drift = p1 + $urandom_range(2 * tol_t);
            p2 = (drift > tol_t) ? drift - tol_t : 0;
        end
        if ($urandom_range(19) == 0)
            now_ts = 32'hFFFF_FFFF - $urandom_range(3000);
        else
            now_ts += $urandom_range(500, 1);
        send_item(CMD_EDGE, LEVEL_RISE, now_ts);
        if (flaw == FRAME_RESTART) begin
            now_ts += $urandom_range(20);
            send_item(CMD_EDGE, LEVEL_RISE, now_ts);
        end
        now_ts += p1;
        send_item(CMD_EDGE, LEVEL_FALL, now_ts);
        if (flaw == FRAME_STALE_TICK)
            send_timeout_tick();
        now_ts += sp;
        if (flaw != FRAME_MISSING_RISE)
            send_item(CMD_EDGE, LEVEL_RISE, now_ts);
        now_ts += p2;
        send_item(CMD_EDGE, LEVEL_FALL, now_ts);
    endtask

    task automatic run_traffic(input int count);
        int target, r;
        target = items_sent + count;
        while (items_sent < target) begin
            r = $urandom_range(99);
            if (r < 72) begin
                send_frame();
            end else if (r < 86) begin
                if ($urandom_range(1))
                    send_timeout_tick();
                else
                    send_item(CMD_TICK, 1'($urandom_range(1)), $urandom());
            end else begin
                send_item(1'($urandom_range(1)), 1'($urandom_range(1)), $urandom());
            end
            if ($urandom_range(29) == 0)
                burst = ~burst;
        end
        burst = 1'b0;
    endtask

    // drop the request line and wait until the block has nothing left to deliver
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic load_settings(input cfg_t setting);
        logic [CFG_DATA_W-1:0] word [8];
        // junk above the 16-bit registers must be dropped by the block
        word[REG_PULSE_SPLIT] = {4'($urandom_range(15)), setting.pulse_split};
        word[REG_PULSE_MIN]   = {4'($urandom_range(15)), setting.pulse_min};
        word[REG_PULSE_MAX]   = {4'($urandom_range(15)), setting.pulse_max};
        word[REG_PULSE_TOL]   = {4'($urandom_range(15)), setting.pulse_tol};
        word[REG_SPACE_MIN]   = {4'($urandom_range(15)), setting.space_min};
        word[REG_SPACE_MAX]   = {4'($urandom_range(15)), setting.space_max};
        word[REG_SPACE_BASE]  = {4'($urandom_range(15)), setting.space_base};
        word[REG_TIMEOUT]     = setting.frame_timeout;
        for (int i = 0; i < 8; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= CFG_IDX_W'(i);
            cfg_data <= word[i];
            do @(posedge aclk); while (!cfg_ready);
        end
        cfg_valid <= 1'b0;
        plan = setting;
    endtask

    initial begin : stimulus
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        plan = '{pulse_split: RST_PULSE_SPLIT, pulse_min: RST_PULSE_MIN,
                 pulse_max: RST_PULSE_MAX, pulse_tol: RST_PULSE_TOL,
                 space_min: RST_SPACE_MIN, space_max: RST_SPACE_MAX,
                 space_base: RST_SPACE_BASE, frame_timeout: RST_TIMEOUT};
        now_ts = $urandom();

        // falling edge and tick while idle
        send_item(CMD_EDGE, LEVEL_FALL, 32'd0);
        send_item(CMD_TICK, LEVEL_FALL, 32'hFFFF_FFFF);
        // clean short-pulse frame
        send_item(CMD_EDGE, LEVEL_RISE, 32'd1000);
        send_item(CMD_EDGE, LEVEL_FALL, 32'd1015);
        send_item(CMD_EDGE, LEVEL_RISE, 32'd1115);
        send_item(CMD_EDGE, LEVEL_FALL, 32'd1130);
        // frame across the timer wrap
        send_item(CMD_EDGE, LEVEL_RISE, 32'hFFFF_FFF0);
        send_item(CMD_EDGE, LEVEL_FALL, 32'hFFFF_FFFF);
        send_item(CMD_EDGE, LEVEL_RISE, 32'h0000_0060);
        send_item(CMD_EDGE, LEVEL_FALL, 32'h0000_0074);
        // restart on a second rise, tick exactly at the limit, long pulses
        send_item(CMD_EDGE, LEVEL_RISE, 32'd5000);
        send_item(CMD_EDGE, LEVEL_RISE, 32'd5010);
        send_item(CMD_EDGE, LEVEL_FALL, 32'd5040);
        send_item(CMD_TICK, LEVEL_FALL, 32'd6040);
        send_item(CMD_EDGE, LEVEL_RISE, 32'd5340);
        send_item(CMD_EDGE, LEVEL_FALL, 32'd5370);
        // falling edge in the space, then a tick just past the limit with level high
        send_item(CMD_EDGE, LEVEL_RISE, 32'd8000);
        send_item(CMD_EDGE, LEVEL_FALL, 32'd8030);
        send_item(CMD_EDGE, LEVEL_FALL, 32'd8040);
        send_item(CMD_EDGE, LEVEL_RISE, 32'd8100);
        send_item(CMD_TICK, LEVEL_RISE, 32'd9101);
        send_item(CMD_EDGE, LEVEL_FALL, 32'd9200);
        // space shorter than the base gives station zero
        send_item(CMD_EDGE, LEVEL_RISE, 32'd20000);
        send_item(CMD_EDGE, LEVEL_FALL, 32'd20020);
        send_item(CMD_EDGE, LEVEL_RISE, 32'd20060);
        send_item(CMD_EDGE, LEVEL_FALL, 32'd20080);
        settle();

        run_traffic(220);
        settle();

        load_settings(random_plan());
        squeeze_req = 1'b1;
        burst = 1'b1;
        run_traffic(220);
        settle();

        load_settings('0);
        run_traffic(120);
        settle();

        // wide windows: station saturates, timeout at its top
        load_settings('{pulse_split: 16'd32768, pulse_min: '0, pulse_max: 16'hFFFF,
                        pulse_tol: 16'hFFFF, space_min: '0, space_max: 16'hFFFF,
                        space_base: '0, frame_timeout: 20'hF_FFFF});
        run_traffic(200);
        settle();

        load_settings('1);
        run_traffic(80);
        settle();

        load_settings(random_plan());
        run_traffic(200);
        settle();

        if (fail_count == 0)
            $display("pulse_space_pulse_frame_decoder: match");
        else
            $display("pulse_space_pulse_frame_decoder: mismatch");
        $finish;
    end

endmodule

// File: sim.f
+incdir+sv
sv/pspf_pkg.sv
sv/pspf_span.sv
sv/pspf_judge.sv
sv/pulse_space_pulse_frame_decoder.sv
sv/pspf_checker.sv
test/frame_decode_checker.sv
test/tb_pulse_space_pulse_frame_decoder.sv
